/* hdl/sudiv_pkg.sv */
package sudiv_pkg;

    localparam int unsigned FIELD_W = 32;

    localparam logic CMD_SIGNED = 1'b1;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

endpackage

/* hdl/signed_unsigned_integer_divider_core.sv */
// Signed/unsigned 32-bit integer divider, restoring radix-2.
// Request channel: i_req_valid/o_req_ready carry command (0 unsigned,
// 1 signed), dividend and divisor. Response channel: o_rsp_valid/
// i_rsp_ready carry quotient and remainder.
// Signed division truncates toward zero; the remainder takes the dividend's
// sign. A zero divisor returns quotient 0 and remainder 0.
// Sequence: the request is taken in idle (magnitudes formed there), then
// the shift-subtract steps, one quotient bit per cycle through a
// single DATA_WIDTH+1 bit subtractor, then a sign fix-up state. The
// response is registered at fix-up, and a new request can be taken only
// once the divider has left fix-up and is back in idle.
// One finished response can wait in the output register while the next
// request is accepted and divided; if it is still not taken at fix-up time,
// the divider holds in fix-up until i_rsp_ready.
// Reset (synchronous, active low) returns to idle with no response pending.
module signed_unsigned_integer_divider_core
    import sudiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd cmd;

    sudiv_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (cmd)
    );

    sudiv_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_req (i_req),
        .o_rsp (o_rsp)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while divider busy");

    a_finish_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_rsp_valid)
        else $error("fix-up did not present a response");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && cmd.step) && !(cmd.load && cmd.finish) && !(cmd.step && cmd.finish))
        else $error("datapath commands overlap");

endmodule

/* hdl/sudiv_ctrl.sv */
module sudiv_ctrl
    import sudiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_dp_cmd o_cmd
);

    localparam int unsigned CW = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_rsp_valid, n_rsp_valid;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    assign o_cmd.load   = i_req_valid && (r_state == S_IDLE);
    assign o_cmd.step   = (r_state == S_CALC);
    assign o_cmd.finish = (r_state == S_FIX) && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_CALC;
                    n_cnt   = CW'(DATA_WIDTH - 1);
                end
            end
            S_CALC: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.finish) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

/* hdl/sudiv_dp.sv */
module sudiv_dp
    import sudiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_rsp    o_rsp
);

    localparam int unsigned DW = DATA_WIDTH;

    logic [DW+FIELD_W-1:0] a_ext, b_ext;
    logic [DW-1:0]         a_w, b_w, ma, mb;
    logic                  a_neg, b_neg;
    logic [DW+1:0]         diff;
    logic                  fits;
    logic [DW-1:0]         q_fix, r_fix;
    logic [DW+FIELD_W-1:0] q_ext, r_ext;

    logic [DW-1:0]         r_rem, r_quo, r_den;
    logic                  r_a_neg, r_q_neg, r_zero;
    t_rsp                  r_rsp;

    // operands are taken in the low DW bits
    assign a_ext = {{DW{1'b0}}, i_req.dividend};
    assign b_ext = {{DW{1'b0}}, i_req.divisor};
    assign a_w   = a_ext[DW-1:0];
    assign b_w   = b_ext[DW-1:0];
    assign a_neg = (i_req.command == CMD_SIGNED) && a_w[DW-1];
    assign b_neg = (i_req.command == CMD_SIGNED) && b_w[DW-1];
    assign ma    = a_neg ? (~a_w + 1'b1) : a_w;
    assign mb    = b_neg ? (~b_w + 1'b1) : b_w;

    // full-width trial subtract
    assign diff = {1'b0, r_rem, r_quo[DW-1]} - {2'b00, r_den};
    assign fits = !diff[DW+1];

    assign q_fix = r_zero ? '0 : (r_q_neg ? (~r_quo + 1'b1) : r_quo);
    assign r_fix = r_zero ? '0 : (r_a_neg ? (~r_rem + 1'b1) : r_rem);
    assign q_ext = {{FIELD_W{1'b0}}, q_fix};
    assign r_ext = {{FIELD_W{1'b0}}, r_fix};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= '0;
            r_quo   <= ma;
            r_den   <= mb;
            r_a_neg <= a_neg;
            r_q_neg <= a_neg ^ b_neg;
            r_zero  <= (b_w == '0);
        end else if (i_cmd.step) begin
            r_rem <= fits ? diff[DW-1:0] : {r_rem[DW-2:0], r_quo[DW-1]};
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp.quotient  <= q_ext[FIELD_W-1:0];
            r_rsp.remainder <= r_ext[FIELD_W-1:0];
        end
    end

    assign o_rsp = r_rsp;

endmodule
